>>> rtl/ftacc_pkg.sv
// Shared types and constants for the fixed tick accumulator.
// Holds the request and response words, codes, FSM state and control structs.
// No dependencies.
package ftacc_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [35:0] amount;
    } req_word_t;

    typedef struct packed {
        logic [4:0]  steps;
        logic        rebased;
        logic        budget_hit;
        logic [35:0] accumulator_now;
        logic [31:0] tick_count;
        logic [31:0] catchup_count;
        logic [31:0] rebase_count;
        logic [31:0] skip_count;
    } rsp_word_t;

    // command codes
    localparam logic [1:0] CMD_ADVANCE_NS  = 2'd0;
    localparam logic [1:0] CMD_ADVANCE_RAW = 2'd1;
    localparam logic [1:0] CMD_REBASE      = 2'd2;

    // register indexes (byte address 4*i)
    localparam logic REG_FIELD_RATE  = 1'b0;
    localparam logic REG_STEP_BUDGET = 1'b1;

    localparam logic [7:0] DEFAULT_FIELD_RATE = 8'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_ADD,
        ST_STEP,
        ST_DONE
    } ftacc_state_t;

    typedef struct packed {
        logic load;
        logic gain;
        logic add;
        logic step;
        logic commit;
    } ftacc_cmd_t;

    typedef struct packed {
        logic step_go;
    } ftacc_status_t;

endpackage

>>> rtl/ftacc_ctrl.sv
// Controller FSM of the fixed tick accumulator.
// Sequences load, gain, add, step and commit; owns the response valid flag.
// Depends on ftacc_pkg.
module ftacc_ctrl
    import ftacc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  ftacc_status_t status,
    output ftacc_cmd_t    cmd
);

    ftacc_state_t state_reg;
    ftacc_state_t state_next;
    logic         valid_reg;
    logic         valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (status.step_go)
                    cmd.step = 1'b1;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
            valid_next = 1'b1;
        else if (rsp_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    assign rsp_valid = valid_reg;

endmodule

>>> rtl/ftacc_dp.sv
// Datapath of the fixed tick accumulator.
// Gain multiplier, stall guard, tick subtractor, statistics counters, output word.
// Depends on ftacc_pkg.
module ftacc_dp
    import ftacc_pkg::*;
#(
    parameter longint unsigned TICK_UNITS   = 64'd2000000000,
    parameter int unsigned     REBASE_TICKS = 30
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  req_word_t     req_word,
    input  logic [7:0]    field_rate,
    input  logic [7:0]    step_budget,
    input  ftacc_cmd_t    cmd,
    output ftacc_status_t status,
    output rsp_word_t     rsp_word
);

    localparam logic [63:0] LIMIT_UNITS = 64'(REBASE_TICKS) * 64'(TICK_UNITS);
    localparam int ACC_W  = $clog2(LIMIT_UNITS + 64'd1);
    localparam int GAIN_W = 44;
    localparam int SUM_W  = ((ACC_W > GAIN_W) ? ACC_W : GAIN_W) + 1;
    localparam int STEP_W = $clog2(REBASE_TICKS + 1);
    localparam logic [ACC_W-1:0] TICK_ACC = ACC_W'(TICK_UNITS);

    logic [1:0]        command_reg;
    logic [35:0]       amount_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [STEP_W-1:0] steps_reg;
    logic [STEP_W-1:0] steps_next;
    logic              advance_reg;
    logic              advance_next;
    logic              rebased_reg;
    logic              rebased_next;
    logic [31:0]       tick_reg, tick_next;
    logic [31:0]       catchup_reg, catchup_next;
    logic [31:0]       rebase_reg, rebase_next;
    logic [31:0]       skip_reg, skip_next;
    rsp_word_t         rsp_reg;
    rsp_word_t         rsp_next;

    logic [7:0]        rate_eff;
    logic [SUM_W-1:0]  sum;
    logic              is_advance;
    logic              guard;
    logic              owe;
    logic              at_budget;
    logic              hit;

    assign rate_eff   = (field_rate == 8'd0) ? DEFAULT_FIELD_RATE : field_rate;
    assign is_advance = (command_reg == CMD_ADVANCE_NS) || (command_reg == CMD_ADVANCE_RAW);
    assign sum        = SUM_W'(acc_reg) + SUM_W'(gain_reg);
    assign guard      = (64'(gain_reg) > LIMIT_UNITS) || (64'(sum) > LIMIT_UNITS);
    assign owe        = acc_reg >= TICK_ACC;
    assign at_budget  = (step_budget != 8'd0) && (8'(steps_reg) == step_budget);
    assign hit        = advance_reg && owe && at_budget;

    assign status.step_go = advance_reg && owe && !at_budget;

    always_comb
    begin
        gain_next    = gain_reg;
        acc_next     = acc_reg;
        steps_next   = steps_reg;
        advance_next = advance_reg;
        rebased_next = rebased_reg;
        tick_next    = tick_reg;
        catchup_next = catchup_reg;
        rebase_next  = rebase_reg;
        skip_next    = skip_reg;
        rsp_next     = rsp_reg;

        if (cmd.load)
        begin
            steps_next   = '0;
            advance_next = 1'b0;
            rebased_next = 1'b0;
        end

        if (cmd.gain)
        begin
            if (command_reg == CMD_ADVANCE_NS)
                gain_next = GAIN_W'(amount_reg) * GAIN_W'(rate_eff);
            else
                gain_next = GAIN_W'(amount_reg);
        end

        if (cmd.add)
        begin
            if ((command_reg == CMD_REBASE) || (is_advance && guard))
            begin
                acc_next     = '0;
                rebased_next = 1'b1;
            end
            else if (is_advance)
            begin
                acc_next     = ACC_W'(sum);
                advance_next = 1'b1;
            end
        end

        if (cmd.step)
        begin
            acc_next   = acc_reg - TICK_ACC;
            steps_next = steps_reg + 1'b1;
        end

        if (cmd.commit)
        begin
            tick_next = tick_reg + 32'(steps_reg);
            if (steps_reg > STEP_W'(1))
                catchup_next = catchup_reg + 32'(steps_reg) - 32'd1;
            if (rebased_reg)
                rebase_next = rebase_reg + 32'd1;
            if (hit)
                skip_next = skip_reg + 32'd1;
            rsp_next.steps           = 5'(steps_reg);
            rsp_next.rebased         = rebased_reg;
            rsp_next.budget_hit      = hit;
            rsp_next.accumulator_now = 36'(acc_reg);
            rsp_next.tick_count      = tick_next;
            rsp_next.catchup_count   = catchup_next;
            rsp_next.rebase_count    = rebase_next;
            rsp_next.skip_count      = skip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            steps_reg   <= '0;
            advance_reg <= 1'b0;
            rebased_reg <= 1'b0;
            tick_reg    <= '0;
            catchup_reg <= '0;
            rebase_reg  <= '0;
            skip_reg    <= '0;
        end
        else
        begin
            acc_reg     <= acc_next;
            steps_reg   <= steps_next;
            advance_reg <= advance_next;
            rebased_reg <= rebased_next;
            tick_reg    <= tick_next;
            catchup_reg <= catchup_next;
            rebase_reg  <= rebase_next;
            skip_reg    <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= req_word.command;
            amount_reg  <= req_word.amount;
        end
        gain_reg <= gain_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_word = rsp_reg;

endmodule

>>> rtl/fixed_tick_accumulator_top.sv
// Fixed tick accumulator top. Each accepted word passes through load, gain, add, the tick loop
// (N ticks, N at most REBASE_TICKS, and at most step_budget when nonzero) and commit.
// The tick subtract loop issues one tick per cycle; a new word is taken only after the last is committed.
// A finished response waits in an output register while the next word is accepted.
// Reset (rst_n low, async): accumulator and counters cleared, field_rate 60, budget 0.
// Depends on ftacc_pkg, ftacc_ctrl, ftacc_dp.
module fixed_tick_accumulator_top
    import ftacc_pkg::*;
#(
    parameter longint unsigned TICK_UNITS   = 64'd2000000000,
    parameter int unsigned     REBASE_TICKS = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  req_word_t   req_word,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp_word,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]    field_rate_reg;
    logic [7:0]    step_budget_reg;
    logic          reg_index;
    logic          cfg_write;
    ftacc_cmd_t    cmd;
    ftacc_status_t status;

    // Word-aligned registers: bit 2 picks the register, low bits are ignored.
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_rate_reg  <= DEFAULT_FIELD_RATE;
            step_budget_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_FIELD_RATE:  field_rate_reg  <= pwdata[7:0];
                REG_STEP_BUDGET: step_budget_reg <= pwdata[7:0];
                default:         field_rate_reg  <= field_rate_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FIELD_RATE:  prdata = {24'd0, field_rate_reg};
            REG_STEP_BUDGET: prdata = {24'd0, step_budget_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Sequencer: one word at a time through gain, add and the tick loop.
    ftacc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, accumulator, statistics and the output register.
    ftacc_dp #(
        .TICK_UNITS   (TICK_UNITS),
        .REBASE_TICKS (REBASE_TICKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_word    (req_word),
        .field_rate  (field_rate_reg),
        .step_budget (step_budget_reg),
        .cmd         (cmd),
        .status      (status),
        .rsp_word    (rsp_word)
    );

`ifndef SYNTH
    // A cleared accumulator never issues ticks.
    a_rebase_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.rebased |-> rsp_word.steps == 5'd0 && !rsp_word.budget_hit)
        else $error("rebased response carries ticks or budget hit");

    // A nonzero budget caps the ticks of one word.
    a_budget_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && step_budget_reg != 8'd0 |-> 8'(rsp_word.steps) <= step_budget_reg)
        else $error("ticks exceed step budget");

    // A budget hit means exactly the budget was issued.
    a_budget_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.budget_hit |-> 8'(rsp_word.steps) == step_budget_reg)
        else $error("budget hit with ticks below budget");

    // After accepting a word the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word accepted back to back");
`endif

endmodule

>>> sim/fixed_tick_accumulator_top_test.sv
`timescale 1ns / 100ps
// Testbench for fixed_tick_accumulator_top: directed and random tick commands over
// several register settings, each response checked against an in-bench tick model.
// Depends on ftacc_pkg and the fixed_tick_accumulator_top RTL.
module fixed_tick_accumulator_top_test;
    import ftacc_pkg::*;

    // One tick is TICK_UNITS accumulator units; the stall guard trips above
    // REBASE_TICKS ticks of gain or of accumulated sum.
    localparam longint unsigned TICK_UNITS     = 64'd2000000000;
    localparam longint unsigned REBASE_TICKS   = 64'd30;
    localparam longint unsigned LIMIT_UNITS    = REBASE_TICKS * TICK_UNITS;
    localparam logic [1:0]      CMD_UNUSED     = 2'd3;
    localparam logic [35:0]     AMOUNT_MAX     = '1;
    localparam int unsigned     CYCLE_LIMIT    = 800000;
    localparam int unsigned     HOLDOFF_CYCLES = 400;
    localparam int unsigned     DRAIN_CYCLES   = 40;
    localparam int unsigned     REPORT_LIMIT   = 10;

    // Tick model plus the queue of responses it predicts. Updated only from
    // the sampling block below and from register writes done while idle.
    class tick_scoreboard;
        rsp_word_t   expected_words[$];
        logic [35:0] accumulator;
        logic [31:0] ticks;
        logic [31:0] catchups;
        logic [31:0] rebases;
        logic [31:0] skips;
        logic [7:0]  field_rate;
        logic [7:0]  step_budget;
        int unsigned mismatches;

        function new();
            accumulator = '0;
            ticks       = '0;
            catchups    = '0;
            rebases     = '0;
            skips       = '0;
            field_rate  = DEFAULT_FIELD_RATE;
            step_budget = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == REG_FIELD_RATE)
                field_rate = value;
            else
                step_budget = value;
        endfunction

        // A zero field rate behaves as the default rate.
        function longint unsigned rate_factor();
            return (field_rate == 0) ? 64'(DEFAULT_FIELD_RATE) : 64'(field_rate);
        endfunction

        function void clear_accumulator(ref rsp_word_t r);
            accumulator = '0;
            rebases     = rebases + 1;
            r.rebased   = 1'b1;
        endfunction

        // Advance the model by one accepted word and queue the response it owes.
        function void take_request(req_word_t w);
            rsp_word_t       r;
            longint unsigned gain;
            longint unsigned total;
            longint unsigned issued;
            r = '0;
            if (w.command == CMD_REBASE) begin
                clear_accumulator(r);
            end
            else if (w.command == CMD_ADVANCE_NS || w.command == CMD_ADVANCE_RAW) begin
                gain = 64'(w.amount);
                if (w.command == CMD_ADVANCE_NS)
                    gain = gain * rate_factor();
                total = 64'(accumulator) + gain;
                if (gain > LIMIT_UNITS || total > LIMIT_UNITS) begin
                    clear_accumulator(r);
                end
                else begin
                    issued = total / TICK_UNITS;
                    if (step_budget != 0 && issued > 64'(step_budget)) begin
                        issued       = 64'(step_budget);
                        r.budget_hit = 1'b1;
                        skips        = skips + 1;
                    end
                    total       = total - issued * TICK_UNITS;
                    accumulator = total[35:0];
                    ticks       = ticks + issued[31:0];
                    if (issued > 1)
                        catchups = catchups + 32'(issued - 1);
                    r.steps = issued[4:0];
                end
            end
            r.accumulator_now = accumulator;
            r.tick_count      = ticks;
            r.catchup_count   = catchups;
            r.rebase_count    = rebases;
            r.skip_count      = skips;
            expected_words.push_back(r);
        endfunction

        function string describe(rsp_word_t w);
            return $sformatf("steps=%0d rebased=%0b hit=%0b acc=%0d ticks=%0d catchup=%0d rebases=%0d skips=%0d",
                             w.steps, w.rebased, w.budget_hit, w.accumulator_now,
                             w.tick_count, w.catchup_count, w.rebase_count, w.skip_count);
        endfunction

        function void flag_mismatch(string msg);
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch: %s", msg);
        endfunction

        // Compare one accepted response with the oldest prediction.
        function void check_result(rsp_word_t got);
            rsp_word_t want;
            if (expected_words.size() == 0) begin
                flag_mismatch({"response with nothing pending: ", describe(got)});
                return;
            end
            want = expected_words.pop_front();
            if (got.steps !== want.steps || got.rebased !== want.rebased
                || got.budget_hit !== want.budget_hit
                || got.accumulator_now !== want.accumulator_now
                || got.tick_count !== want.tick_count
                || got.catchup_count !== want.catchup_count
                || got.rebase_count !== want.rebase_count
                || got.skip_count !== want.skip_count)
                flag_mismatch({"expected ", describe(want), "\n          actual   ", describe(got)});
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_word_t   req_word;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_word_t   rsp_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tick_scoreboard sb = new();
    int unsigned    cycle_count = 0;
    // Idling is switched off for the final stretch of the run.
    bit             idling_on = 1'b1;
    // Ask the response side for one long stall while words keep coming.
    bit             hold_responses = 1'b0;

    fixed_tick_accumulator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sample both handshakes at the edge: values seen here are the ones the
    // block sampled, since every driver updates with nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && req_ready)
                sb.take_request(req_word);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp_word);
        end
    end

    // Watchdog: drop the run if it goes far past the slowest correct finish.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Response side: ready in random stretches, stalls in random bursts,
    // and one long hold-off on request. Exactly one assignment per pass,
    // and every pass waits on the clock before the next.
    initial
    begin : rsp_side
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_responses) begin
                hold_responses = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 3) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic req_word_t make_word(logic [1:0] command, logic [35:0] amount);
        req_word_t w;
        w.command = command;
        w.amount  = amount;
        return w;
    endfunction

    // Mostly well-formed advances whose gain sits around a few ticks, some up to
    // past the stall guard, plus rebases, full-range noise and the unused code.
    function automatic req_word_t random_word();
        req_word_t       w;
        int unsigned     pick;
        longint unsigned r64;
        pick      = $urandom_range(0, 99);
        r64       = {$urandom(), $urandom()};
        w.command = CMD_ADVANCE_NS;
        w.amount  = r64[35:0];
        if (pick < 40)
            w.amount = 36'((r64 % (3 * TICK_UNITS)) / sb.rate_factor());
        else if (pick < 55)
            w.amount = 36'((r64 % ((REBASE_TICKS + 2) * TICK_UNITS)) / sb.rate_factor());
        else if (pick < 60)
            w.command = CMD_ADVANCE_NS;
        else if (pick < 78) begin
            w.command = CMD_ADVANCE_RAW;
            w.amount  = 36'(r64 % (3 * TICK_UNITS));
        end
        else if (pick < 86) begin
            w.command = CMD_ADVANCE_RAW;
            w.amount  = 36'(r64 % ((REBASE_TICKS + 2) * TICK_UNITS));
        end
        else if (pick < 90)
            w.command = CMD_ADVANCE_RAW;
        else if (pick < 96)
            w.command = CMD_REBASE;
        else
            w.command = CMD_UNUSED;
        return w;
    endfunction

    // Offer one word, maybe after a short gap, and hold it until accepted.
    // Valid stays high on return so back-to-back words need no re-raise.
    task automatic send_word(input req_word_t w);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Setup cycle, access cycle; the register takes the value at the edge that
    // ends the access cycle. Upper data bits carry junk the block must drop.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        logic [31:0] junk;
        junk = $urandom();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Wait for an edge so the last accepted word is noted, then for every
    // predicted response to come back, then let the block settle.
    task automatic wait_idle();
        @(posedge clk);
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] rate, input logic [7:0] budget,
                             input int unsigned count);
        write_reg(REG_FIELD_RATE, rate);
        write_reg(REG_STEP_BUDGET, budget);
        repeat (count) send_word(random_word());
        req_valid <= 1'b0;
        wait_idle();
    endtask

    initial
    begin : stimulus
        req_word_t directed[$];

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_word  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words at reset settings (60 Hz, no budget).
        directed.push_back(make_word(CMD_ADVANCE_NS, 36'd0));
        // just under one tick, then 40 units over it
        directed.push_back(make_word(CMD_ADVANCE_NS, 36'd33333333));
        directed.push_back(make_word(CMD_ADVANCE_NS, 36'd1));
        // accumulator one unit short of a tick, then exactly on it
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'd1999999959));
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'd1));
        // gain exactly at the guard limit issues the full thirty ticks
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'(LIMIT_UNITS)));
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'(LIMIT_UNITS + 1)));
        // guard tripped by the sum although the gain alone fits
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'd1900000000));
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'd58500000000));
        directed.push_back(make_word(CMD_ADVANCE_RAW, AMOUNT_MAX));
        directed.push_back(make_word(CMD_ADVANCE_NS, AMOUNT_MAX));
        directed.push_back(make_word(CMD_ADVANCE_NS, 36'd1000000000));
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'd5000000000));
        directed.push_back(make_word(CMD_REBASE, AMOUNT_MAX));
        directed.push_back(make_word(CMD_REBASE, 36'd0));
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'd3000000000));
        directed.push_back(make_word(CMD_UNUSED, AMOUNT_MAX));
        directed.push_back(make_word(CMD_UNUSED, 36'd0));
        directed.push_back(make_word(CMD_ADVANCE_NS, 36'hAAAAAAAAA));
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'h555555555));
        directed.push_back(make_word(CMD_ADVANCE_RAW, 36'h0AAAAAAAA));
        foreach (directed[i])
            send_word(directed[i]);
        req_valid <= 1'b0;
        wait_idle();

        // Random phases across the register extremes. Zero rate acts as 60;
        // budget one stops stepping often and lets the accumulator climb.
        run_phase(8'd0, 8'd0, 200);
        hold_responses = 1'b1;
        run_phase(8'd255, 8'd1, 200);
        run_phase(8'd1, 8'd255, 200);
        run_phase(8'd60, 8'd3, 250);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 5)), 250);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 200);

        // Final stretch at full rate on both sides.
        idling_on = 1'b0;
        run_phase(8'd60, 8'd2, 225);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
